// File: rtl/core/v4flt_pkg.sv
// Shared types and constants for the IPv4 five-tuple frame filter.
package v4flt_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned OffsetW = 6;
  localparam int unsigned LenW = OffsetW + 1;

  localparam logic [OffsetW-1:0] OffsetMax = 6'd63;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_IPV4_ENABLE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SRC_ADDR = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DST_ADDR = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SRC_PORT = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DST_PORT = 3'd4;

  localparam logic [15:0] ETYPE_ARP = 16'h0806;
  localparam logic [15:0] ETYPE_RARP = 16'h8035;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // Header byte offsets
  localparam logic [OffsetW-1:0] OFS_ETYPE_HI = 6'd12;
  localparam logic [OffsetW-1:0] OFS_ETYPE_LO = 6'd13;
  localparam logic [OffsetW-1:0] OFS_PROTO = 6'd23;
  localparam logic [OffsetW-1:0] OFS_SRC_ADDR_FIRST = 6'd26;
  localparam logic [OffsetW-1:0] OFS_SRC_ADDR_LAST = 6'd29;
  localparam logic [OffsetW-1:0] OFS_DST_ADDR_FIRST = 6'd30;
  localparam logic [OffsetW-1:0] OFS_DST_ADDR_LAST = 6'd33;
  localparam logic [OffsetW-1:0] OFS_SRC_PORT_HI = 6'd34;
  localparam logic [OffsetW-1:0] OFS_SRC_PORT_LO = 6'd35;
  localparam logic [OffsetW-1:0] OFS_DST_PORT_HI = 6'd36;
  localparam logic [OffsetW-1:0] OFS_DST_PORT_LO = 6'd37;

  // Minimum frame lengths
  localparam logic [LenW-1:0] ETH_HDR_LEN = 7'd14;
  localparam logic [LenW-1:0] IP_HDR_END = 7'd34;
  localparam logic [LenW-1:0] UDP_HDR_END = 7'd42;
  localparam logic [LenW-1:0] TCP_HDR_END = 7'd54;

  typedef enum logic [3:0] {
    REASON_ARP         = 4'd0,
    REASON_NOT_IPV4    = 4'd1,
    REASON_TRUNCATED   = 4'd2,
    REASON_SRC_ADDR    = 4'd3,
    REASON_DST_ADDR    = 4'd4,
    REASON_OTHER_PROTO = 4'd5,
    REASON_SRC_PORT    = 4'd6,
    REASON_DST_PORT    = 4'd7,
    REASON_ALL_MATCHED = 4'd8
  } reason_e;

  typedef struct packed {
    logic        ipv4_enable;
    logic [31:0] src_addr_match;
    logic [31:0] dst_addr_match;
    logic [15:0] src_port_match;
    logic [15:0] dst_port_match;
  } cfg_t;

  typedef struct packed {
    logic [15:0] ether_type;
    logic [7:0]  transport_proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
  } hdr_t;

  // Parser to verdict: final word of a frame with its header and length
  typedef struct packed {
    logic            fire;
    logic [LenW-1:0] len;
    hdr_t            hdr;
  } frame_end_t;

endpackage

// File: rtl/core/ipv4_five_tuple_packet_filter.sv
// Top level of the IPv4 five-tuple frame filter.
// Takes one frame word (byte) per clock and gives one accept/drop verdict with a
// reason code per frame, presented from the result register once the word marked
// last has passed the input register. Each word passes an input register, then
// field capture and the verdict compare, then the result register, so a new word
// is taken every cycle; the input stalls only while a verdict sits in the result
// register under out_stall_i and the next frame's last word waits behind it. The
// IP header is taken as 20 bytes. Configuration is written through
// cfg_valid_i/cfg_index_i/cfg_data_i, always ready, and must only change while
// no frame is in flight.
module ipv4_five_tuple_packet_filter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [v4flt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [v4flt_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     frame_byte_i,
  input  logic                           frame_last_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           accept_o,
  output logic [3:0]                     reason_o
);

  v4flt_pkg::cfg_t       cfg;
  v4flt_pkg::frame_end_t frame_end;
  logic                  out_free;

  assign cfg_ready_o = 1'b1;

  v4flt_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  v4flt_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .frame_byte_i(frame_byte_i),
    .frame_last_i(frame_last_i),
    .out_free_i  (out_free),
    .frame_end_o (frame_end)
  );

  v4flt_verdict u_verdict (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .frame_end_i(frame_end),
    .out_free_o (out_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .accept_o   (accept_o),
    .reason_o   (reason_o)
  );

endmodule

// File: rtl/core/v4flt_cfg_regs.sv
// Configuration register file of the frame filter.
module v4flt_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [v4flt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [v4flt_pkg::CfgDataW-1:0] cfg_data_i,
  output v4flt_pkg::cfg_t                cfg_o
);

  v4flt_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        v4flt_pkg::CFG_IPV4_ENABLE: cfg_d.ipv4_enable = cfg_data_i[0];
        v4flt_pkg::CFG_SRC_ADDR:    cfg_d.src_addr_match = cfg_data_i;
        v4flt_pkg::CFG_DST_ADDR:    cfg_d.dst_addr_match = cfg_data_i;
        v4flt_pkg::CFG_SRC_PORT:    cfg_d.src_port_match = cfg_data_i[15:0];
        v4flt_pkg::CFG_DST_PORT:    cfg_d.dst_port_match = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{ipv4_enable: 1'b1, src_addr_match: 32'd0, dst_addr_match: 32'd0,
                 src_port_match: 16'd0, dst_port_match: 16'd0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/v4flt_parser.sv
// Input word register and header field capture of the frame filter.
module v4flt_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  frame_byte_i,
  input  logic                        frame_last_i,
  input  logic                        out_free_i,
  output v4flt_pkg::frame_end_t       frame_end_o
);

  logic                            s1_valid_q, s1_valid_d;
  logic [7:0]                      s1_byte_q;
  logic                            s1_last_q;
  logic [v4flt_pkg::OffsetW-1:0]   offset_q, offset_d;
  v4flt_pkg::hdr_t                 hdr_q, hdr_d, hdr_cap;
  logic                            advance;
  logic                            in_take;
  logic [v4flt_pkg::OffsetW-1:0]   pos;

  // A last word waits in s1 only while the result register is held
  assign advance = s1_valid_q && (!s1_last_q || out_free_i);
  assign in_stall_o = s1_valid_q && s1_last_q && !out_free_i;
  assign in_take = in_valid_i && !in_stall_o;
  assign pos = offset_q;

  always_comb begin
    hdr_cap = hdr_q;
    if (pos == v4flt_pkg::OFS_ETYPE_HI || pos == v4flt_pkg::OFS_ETYPE_LO) begin
      hdr_cap.ether_type = {hdr_q.ether_type[7:0], s1_byte_q};
    end
    if (pos == v4flt_pkg::OFS_PROTO) begin
      hdr_cap.transport_proto = s1_byte_q;
    end
    if (pos >= v4flt_pkg::OFS_SRC_ADDR_FIRST && pos <= v4flt_pkg::OFS_SRC_ADDR_LAST) begin
      hdr_cap.src_addr = {hdr_q.src_addr[23:0], s1_byte_q};
    end
    if (pos >= v4flt_pkg::OFS_DST_ADDR_FIRST && pos <= v4flt_pkg::OFS_DST_ADDR_LAST) begin
      hdr_cap.dst_addr = {hdr_q.dst_addr[23:0], s1_byte_q};
    end
    if (pos == v4flt_pkg::OFS_SRC_PORT_HI || pos == v4flt_pkg::OFS_SRC_PORT_LO) begin
      hdr_cap.sport = {hdr_q.sport[7:0], s1_byte_q};
    end
    if (pos == v4flt_pkg::OFS_DST_PORT_HI || pos == v4flt_pkg::OFS_DST_PORT_LO) begin
      hdr_cap.dport = {hdr_q.dport[7:0], s1_byte_q};
    end
  end

  always_comb begin
    hdr_d = hdr_q;
    offset_d = offset_q;
    if (advance) begin
      if (s1_last_q) begin
        hdr_d = '0;
        offset_d = '0;
      end else begin
        hdr_d = hdr_cap;
        if (offset_q != v4flt_pkg::OffsetMax) begin
          offset_d = offset_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      offset_q <= '0;
      hdr_q <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      offset_q <= offset_d;
      hdr_q <= hdr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= frame_byte_i;
      s1_last_q <= frame_last_i;
    end
  end

  // Offset 63 is past the capture window, so hdr_cap leaves it alone
  assign frame_end_o.fire = advance && s1_last_q;
  assign frame_end_o.len = {1'b0, offset_q} + 7'd1;
  assign frame_end_o.hdr = hdr_cap;

endmodule

// File: rtl/core/v4flt_verdict.sv
// Accept/drop decision and result register of the frame filter.
module v4flt_verdict (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  v4flt_pkg::cfg_t       cfg_i,
  input  v4flt_pkg::frame_end_t frame_end_i,
  output logic                  out_free_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  accept_o,
  output logic [3:0]            reason_o
);

  logic                       out_valid_q, out_valid_d;
  logic                       accept_q, accept_d;
  v4flt_pkg::reason_e         reason_q, reason_d;
  v4flt_pkg::hdr_t            hdr;
  logic [v4flt_pkg::LenW-1:0] len;
  logic                       is_udp, is_tcp;
  logic                       transport_short;

  assign hdr = frame_end_i.hdr;
  assign len = frame_end_i.len;
  assign is_udp = hdr.transport_proto == v4flt_pkg::PROTO_UDP;
  assign is_tcp = hdr.transport_proto == v4flt_pkg::PROTO_TCP;
  assign transport_short = (is_udp && len < v4flt_pkg::UDP_HDR_END)
                        || (is_tcp && len < v4flt_pkg::TCP_HDR_END);

  always_comb begin
    priority if (len < v4flt_pkg::ETH_HDR_LEN) begin
      accept_d = 1'b1;
      reason_d = v4flt_pkg::REASON_TRUNCATED;
    end else if (hdr.ether_type == v4flt_pkg::ETYPE_ARP
              || hdr.ether_type == v4flt_pkg::ETYPE_RARP) begin
      accept_d = 1'b1;
      reason_d = v4flt_pkg::REASON_ARP;
    end else if (hdr.ether_type != v4flt_pkg::ETYPE_IPV4 || !cfg_i.ipv4_enable) begin
      accept_d = 1'b0;
      reason_d = v4flt_pkg::REASON_NOT_IPV4;
    end else if (len < v4flt_pkg::IP_HDR_END) begin
      accept_d = 1'b1;
      reason_d = v4flt_pkg::REASON_TRUNCATED;
    end else if (cfg_i.src_addr_match != '0 && hdr.src_addr != cfg_i.src_addr_match) begin
      accept_d = 1'b0;
      reason_d = v4flt_pkg::REASON_SRC_ADDR;
    end else if (cfg_i.dst_addr_match != '0 && hdr.dst_addr != cfg_i.dst_addr_match) begin
      accept_d = 1'b0;
      reason_d = v4flt_pkg::REASON_DST_ADDR;
    end else if (!is_udp && !is_tcp) begin
      accept_d = 1'b0;
      reason_d = v4flt_pkg::REASON_OTHER_PROTO;
    end else if (transport_short) begin
      accept_d = 1'b1;
      reason_d = v4flt_pkg::REASON_TRUNCATED;
    end else if (cfg_i.src_port_match != '0 && hdr.sport != cfg_i.src_port_match) begin
      accept_d = 1'b0;
      reason_d = v4flt_pkg::REASON_SRC_PORT;
    end else if (cfg_i.dst_port_match != '0 && hdr.dport != cfg_i.dst_port_match) begin
      accept_d = 1'b1;
      reason_d = v4flt_pkg::REASON_DST_PORT;
    end else begin
      accept_d = 1'b0;
      reason_d = v4flt_pkg::REASON_ALL_MATCHED;
    end
  end

  assign out_free_o = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (frame_end_i.fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_end_i.fire) begin
      accept_q <= accept_d;
      reason_q <= reason_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign accept_o = accept_q;
  assign reason_o = reason_q;

endmodule

// File: rtl/core/v4flt_checker.sv
// Port-level checker for the frame filter, bound to the top level.
module v4flt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       accept_o,
  input logic [3:0] reason_o
);

  // A held result word keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(accept_o) && $stable(reason_o))
    else $error("stalled result changed");

  // The input only backs up behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free result register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> reason_o <= v4flt_pkg::REASON_ALL_MATCHED)
    else $error("reason out of range");

  // Keep verdicts are exactly arp, truncated and destination port differs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> accept_o == (reason_o == v4flt_pkg::REASON_ARP
                              || reason_o == v4flt_pkg::REASON_TRUNCATED
                              || reason_o == v4flt_pkg::REASON_DST_PORT))
    else $error("accept does not agree with reason");

endmodule

bind ipv4_five_tuple_packet_filter v4flt_checker u_v4flt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .accept_o   (accept_o),
  .reason_o   (reason_o)
);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the IPv4 five-tuple frame filter.
`timescale 1ns / 1ps

module tb_top;

  localparam int CycleLimit = 200000;
  localparam int PhaseWords = 80;
  localparam logic [v4flt_pkg::CfgIdxW-1:0] CfgIdxUnused = 3'd7;
  localparam logic [15:0] EthPIpv6 = 16'h86DD;
  localparam logic [7:0] IpProtoIcmp = 8'd1;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } word_t;

  typedef struct packed {
    logic               accept;
    v4flt_pkg::reason_e reason;
  } verdict_t;

  typedef enum int {RxFree, RxLight, RxHeavy, RxPeriodic} rx_mode_e;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [v4flt_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [v4flt_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [7:0]                     frame_byte_i = '0;
  logic                           frame_last_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic                           accept_o;
  logic [3:0]                     reason_o;

  // predictor state
  v4flt_pkg::cfg_t               filt_cfg;
  v4flt_pkg::hdr_t               cur_hdr;
  logic [v4flt_pkg::OffsetW-1:0] cur_ofs;

  word_t    word_q[$];
  verdict_t verdict_q[$];

  int       queued_words = 0;
  int       err_cnt = 0;
  int       cycle_cnt = 0;
  logic     in_taken = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;
  bit       rx_long_hold_req = 1'b0;
  int       rx_hold_left = 0;
  int       rx_mode_left = 0;
  rx_mode_e rx_mode = RxFree;

  ipv4_five_tuple_packet_filter uut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .frame_byte_i,
    .frame_last_i,
    .out_valid_o,
    .out_stall_i,
    .accept_o,
    .reason_o
  );

  always #6 clk_i = ~clk_i;

  function automatic verdict_t verdict_of(logic acc, v4flt_pkg::reason_e why);
    verdict_t v;
    v.accept = acc;
    v.reason = why;
    return v;
  endfunction

  // Advance the predictor by one word; returns 1 when the word closes a frame.
  function automatic bit filter_word(input logic [7:0] b, input logic last,
                                     output verdict_t v);
    logic [v4flt_pkg::OffsetW-1:0] pos;
    logic [v4flt_pkg::LenW-1:0]    len;
    logic [v4flt_pkg::LenW-1:0]    need;
    pos = cur_ofs;
    v = verdict_of(1'b0, v4flt_pkg::REASON_ALL_MATCHED);
    if (pos != v4flt_pkg::OffsetMax) begin
      if (pos == v4flt_pkg::OFS_ETYPE_HI || pos == v4flt_pkg::OFS_ETYPE_LO) begin
        cur_hdr.ether_type = {cur_hdr.ether_type[7:0], b};
      end else if (pos == v4flt_pkg::OFS_PROTO) begin
        cur_hdr.transport_proto = b;
      end else if (pos >= v4flt_pkg::OFS_SRC_ADDR_FIRST &&
                   pos <= v4flt_pkg::OFS_SRC_ADDR_LAST) begin
        cur_hdr.src_addr = {cur_hdr.src_addr[23:0], b};
      end else if (pos >= v4flt_pkg::OFS_DST_ADDR_FIRST &&
                   pos <= v4flt_pkg::OFS_DST_ADDR_LAST) begin
        cur_hdr.dst_addr = {cur_hdr.dst_addr[23:0], b};
      end else if (pos == v4flt_pkg::OFS_SRC_PORT_HI || pos == v4flt_pkg::OFS_SRC_PORT_LO) begin
        cur_hdr.sport = {cur_hdr.sport[7:0], b};
      end else if (pos == v4flt_pkg::OFS_DST_PORT_HI || pos == v4flt_pkg::OFS_DST_PORT_LO) begin
        cur_hdr.dport = {cur_hdr.dport[7:0], b};
      end
    end
    if (!last) begin
      if (pos != v4flt_pkg::OffsetMax) cur_ofs = pos + 1'b1;
      return 1'b0;
    end
    // length counts the last word and saturates at 64
    len = {1'b0, pos} + 1'b1;
    need = (cur_hdr.transport_proto == v4flt_pkg::PROTO_UDP) ? v4flt_pkg::UDP_HDR_END :
                                                                v4flt_pkg::TCP_HDR_END;
    if (len < v4flt_pkg::ETH_HDR_LEN) begin
      v = verdict_of(1'b1, v4flt_pkg::REASON_TRUNCATED);
    end else if (cur_hdr.ether_type == v4flt_pkg::ETYPE_ARP ||
                 cur_hdr.ether_type == v4flt_pkg::ETYPE_RARP) begin
      v = verdict_of(1'b1, v4flt_pkg::REASON_ARP);
    end else if (cur_hdr.ether_type != v4flt_pkg::ETYPE_IPV4 || !filt_cfg.ipv4_enable) begin
      v = verdict_of(1'b0, v4flt_pkg::REASON_NOT_IPV4);
    end else if (len < v4flt_pkg::IP_HDR_END) begin
      v = verdict_of(1'b1, v4flt_pkg::REASON_TRUNCATED);
    end else if (filt_cfg.src_addr_match != 0 &&
                 cur_hdr.src_addr != filt_cfg.src_addr_match) begin
      v = verdict_of(1'b0, v4flt_pkg::REASON_SRC_ADDR);
    end else if (filt_cfg.dst_addr_match != 0 &&
                 cur_hdr.dst_addr != filt_cfg.dst_addr_match) begin
      v = verdict_of(1'b0, v4flt_pkg::REASON_DST_ADDR);
    end else if (cur_hdr.transport_proto != v4flt_pkg::PROTO_UDP &&
                 cur_hdr.transport_proto != v4flt_pkg::PROTO_TCP) begin
      v = verdict_of(1'b0, v4flt_pkg::REASON_OTHER_PROTO);
    end else if (len < need) begin
      v = verdict_of(1'b1, v4flt_pkg::REASON_TRUNCATED);
    end else if (filt_cfg.src_port_match != 0 &&
                 cur_hdr.sport != filt_cfg.src_port_match) begin
      v = verdict_of(1'b0, v4flt_pkg::REASON_SRC_PORT);
    end else if (filt_cfg.dst_port_match != 0 &&
                 cur_hdr.dport != filt_cfg.dst_port_match) begin
      v = verdict_of(1'b1, v4flt_pkg::REASON_DST_PORT);
    end
    cur_hdr = '0;
    cur_ofs = '0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic write_reg(input logic [v4flt_pkg::CfgIdxW-1:0] idx,
                           input logic [v4flt_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    unique case (idx)
      v4flt_pkg::CFG_IPV4_ENABLE: filt_cfg.ipv4_enable = val[0];
      v4flt_pkg::CFG_SRC_ADDR:    filt_cfg.src_addr_match = val;
      v4flt_pkg::CFG_DST_ADDR:    filt_cfg.dst_addr_match = val;
      v4flt_pkg::CFG_SRC_PORT:    filt_cfg.src_port_match = val[15:0];
      v4flt_pkg::CFG_DST_PORT:    filt_cfg.dst_port_match = val[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_frame(input int len, input logic [15:0] etype, input logic [7:0] proto,
                            input logic [31:0] sa, input logic [31:0] da,
                            input logic [15:0] sp, input logic [15:0] dp);
    word_t w;
    for (int i = 0; i < len; i++) begin
      w.data = 8'($urandom_range(0, 255));
      if (i == v4flt_pkg::OFS_ETYPE_HI) begin
        w.data = etype[15:8];
      end else if (i == v4flt_pkg::OFS_ETYPE_LO) begin
        w.data = etype[7:0];
      end else if (i == v4flt_pkg::OFS_PROTO) begin
        w.data = proto;
      end else if (i >= v4flt_pkg::OFS_SRC_ADDR_FIRST && i <= v4flt_pkg::OFS_SRC_ADDR_LAST) begin
        w.data = 8'(sa >> (8 * (v4flt_pkg::OFS_SRC_ADDR_LAST - i)));
      end else if (i >= v4flt_pkg::OFS_DST_ADDR_FIRST && i <= v4flt_pkg::OFS_DST_ADDR_LAST) begin
        w.data = 8'(da >> (8 * (v4flt_pkg::OFS_DST_ADDR_LAST - i)));
      end else if (i == v4flt_pkg::OFS_SRC_PORT_HI) begin
        w.data = sp[15:8];
      end else if (i == v4flt_pkg::OFS_SRC_PORT_LO) begin
        w.data = sp[7:0];
      end else if (i == v4flt_pkg::OFS_DST_PORT_HI) begin
        w.data = dp[15:8];
      end else if (i == v4flt_pkg::OFS_DST_PORT_LO) begin
        w.data = dp[7:0];
      end
      w.last = (i == len - 1);
      word_q.push_back(w);
      queued_words++;
    end
  endtask

  task automatic push_fill_frame(input int len, input logic [7:0] val);
    word_t w;
    for (int i = 0; i < len; i++) begin
      w.data = val;
      w.last = (i == len - 1);
      word_q.push_back(w);
      queued_words++;
    end
  endtask

  // Mostly well-formed headers, biased toward the programmed match values.
  task automatic push_random_frame(input bit short_frames);
    int          len;
    int          r;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sp;
    logic [15:0] dp;
    if (short_frames) begin
      len = $urandom_range(1, 24);
    end else begin
      r = $urandom_range(0, 9);
      unique case (r)
        0: len = $urandom_range(1, 13);
        1: len = $urandom_range(14, 33);
        2: len = $urandom_range(34, 41);
        3: len = $urandom_range(42, 53);
        9: len = $urandom_range(65, 80);
        default: len = $urandom_range(54, 64);
      endcase
    end
    r = $urandom_range(0, 19);
    if (r < 13) etype = v4flt_pkg::ETYPE_IPV4;
    else if (r == 13) etype = v4flt_pkg::ETYPE_ARP;
    else if (r == 14) etype = v4flt_pkg::ETYPE_RARP;
    else etype = 16'($urandom_range(0, 16'hFFFF));
    r = $urandom_range(0, 9);
    if (r < 5) proto = v4flt_pkg::PROTO_UDP;
    else if (r < 8) proto = v4flt_pkg::PROTO_TCP;
    else proto = 8'($urandom_range(0, 255));
    sa = (filt_cfg.src_addr_match != 0 && $urandom_range(0, 3) != 0) ?
         filt_cfg.src_addr_match : $urandom();
    da = (filt_cfg.dst_addr_match != 0 && $urandom_range(0, 3) != 0) ?
         filt_cfg.dst_addr_match : $urandom();
    sp = (filt_cfg.src_port_match != 0 && $urandom_range(0, 3) != 0) ?
         filt_cfg.src_port_match : 16'($urandom());
    dp = (filt_cfg.dst_port_match != 0 && $urandom_range(0, 1) != 0) ?
         filt_cfg.dst_port_match : 16'($urandom());
    push_frame(len, etype, proto, sa, da, sp, dp);
  endtask

  function automatic logic [31:0] pick_match(input logic [31:0] top);
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return '0;
    if (r == 3) return top;
    return $urandom() & top;
  endfunction

  // Blocks until the sender is empty and every verdict is in, then lets the pipe settle.
  task automatic wait_drained();
    do @(posedge clk_i); while (word_q.size() != 0 || in_valid_i || verdict_q.size() != 0);
    repeat (6) @(posedge clk_i);
  endtask

  // Sender: bursts of words with random gaps between them.
  always @(negedge clk_i) begin : drive_words
    word_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (word_q.size() != 0) begin
        w = word_q.pop_front();
        frame_byte_i <= w.data;
        frame_last_i <= w.last;
        in_valid_i <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
                       $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern switches mode every so often; long hold on request.
  always @(negedge clk_i) begin : drive_stall
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (rx_long_hold_req) begin
        rx_hold_left = 400;
        rx_long_hold_req = 1'b0;
      end
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 120);
      end else begin
        rx_mode_left--;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        unique case (rx_mode)
          RxFree:  out_stall_i <= 1'b0;
          RxLight: out_stall_i <= ($urandom_range(0, 3) == 0);
          RxHeavy: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ((rx_mode_left % 7) < 3);
        endcase
      end
    end
  end

  // Predict on accepted input words, then check accepted verdicts in order.
  always @(posedge clk_i) begin : check_verdicts
    verdict_t pred;
    verdict_t exp_v;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        if (filter_word(frame_byte_i, frame_last_i, pred)) verdict_q.push_back(pred);
      end
      if (out_valid_o && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("verdict accept=%0b reason=%0d with no frame pending",
                                    accept_o, reason_o));
        end else begin
          exp_v = verdict_q.pop_front();
          if (accept_o !== exp_v.accept)
            report_mismatch($sformatf("accept %0b, expected %0b (reason %0d)",
                                      accept_o, exp_v.accept, exp_v.reason));
          if (reason_o !== exp_v.reason)
            report_mismatch($sformatf("reason %0d, expected %0d", reason_o, exp_v.reason));
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      report_mismatch($sformatf("timeout with %0d verdicts outstanding", verdict_q.size()));
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int target;
    filt_cfg = '0;
    filt_cfg.ipv4_enable = 1'b1;
    cur_hdr = '0;
    cur_ofs = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: length thresholds, ethertypes, protocols, saturation
    push_fill_frame(1, 8'hFF);
    push_frame(13, v4flt_pkg::ETYPE_IPV4, v4flt_pkg::PROTO_UDP, $urandom(), $urandom(),
               16'd1, 16'd2);
    push_frame(14, v4flt_pkg::ETYPE_ARP, v4flt_pkg::PROTO_UDP, $urandom(), $urandom(),
               16'd1, 16'd2);
    push_frame(60, v4flt_pkg::ETYPE_RARP, v4flt_pkg::PROTO_TCP, $urandom(), $urandom(),
               16'd1, 16'd2);
    push_frame(14, v4flt_pkg::ETYPE_IPV4, v4flt_pkg::PROTO_TCP, $urandom(), $urandom(),
               16'd1, 16'd2);
    push_frame(40, EthPIpv6, v4flt_pkg::PROTO_UDP, $urandom(), $urandom(), 16'd1, 16'd2);
    push_frame(33, v4flt_pkg::ETYPE_IPV4, v4flt_pkg::PROTO_UDP, $urandom(), $urandom(),
               16'd1, 16'd2);
    push_frame(34, v4flt_pkg::ETYPE_IPV4, IpProtoIcmp, $urandom(), $urandom(), 16'd1, 16'd2);
    push_frame(41, v4flt_pkg::ETYPE_IPV4, v4flt_pkg::PROTO_UDP, $urandom(), $urandom(),
               16'd1, 16'd2);
    push_frame(42, v4flt_pkg::ETYPE_IPV4, v4flt_pkg::PROTO_UDP, $urandom(), $urandom(),
               16'd1, 16'd2);
    push_frame(53, v4flt_pkg::ETYPE_IPV4, v4flt_pkg::PROTO_TCP, $urandom(), $urandom(),
               16'd1, 16'd2);
    push_frame(54, v4flt_pkg::ETYPE_IPV4, v4flt_pkg::PROTO_TCP, $urandom(), $urandom(),
               16'd1, 16'd2);
    push_frame(80, v4flt_pkg::ETYPE_IPV4, v4flt_pkg::PROTO_UDP, $urandom(), $urandom(),
               16'd1, 16'd2);
    push_fill_frame(64, 8'h00);
    push_fill_frame(70, 8'hFF);
    wait_drained();

    // IPv4 disabled: ARP still passes
    write_reg(v4flt_pkg::CFG_IPV4_ENABLE, 32'd0);
    push_frame(60, v4flt_pkg::ETYPE_IPV4, v4flt_pkg::PROTO_UDP, $urandom(), $urandom(),
               16'd1, 16'd2);
    push_frame(20, v4flt_pkg::ETYPE_ARP, v4flt_pkg::PROTO_UDP, $urandom(), $urandom(),
               16'd1, 16'd2);
    push_frame(5, v4flt_pkg::ETYPE_IPV4, v4flt_pkg::PROTO_UDP, $urandom(), $urandom(),
               16'd1, 16'd2);
    wait_drained();

    // one mismatch per compare stage
    write_reg(v4flt_pkg::CFG_IPV4_ENABLE, 32'd1);
    write_reg(v4flt_pkg::CFG_SRC_ADDR, 32'hC0A8_0001);
    write_reg(v4flt_pkg::CFG_DST_ADDR, 32'h0A00_0002);
    write_reg(v4flt_pkg::CFG_SRC_PORT, 32'd1234);
    write_reg(v4flt_pkg::CFG_DST_PORT, 32'd80);
    push_frame(60, v4flt_pkg::ETYPE_IPV4, v4flt_pkg::PROTO_UDP, 32'hC0A8_0002, 32'h0A00_0002,
               16'd1234, 16'd80);
    push_frame(60, v4flt_pkg::ETYPE_IPV4, v4flt_pkg::PROTO_UDP, 32'hC0A8_0001, 32'h0A00_0003,
               16'd1234, 16'd80);
    push_frame(60, v4flt_pkg::ETYPE_IPV4, IpProtoIcmp, 32'hC0A8_0001, 32'h0A00_0002,
               16'd1234, 16'd80);
    push_frame(60, v4flt_pkg::ETYPE_IPV4, v4flt_pkg::PROTO_UDP, 32'hC0A8_0001, 32'h0A00_0002,
               16'd1235, 16'd80);
    push_frame(60, v4flt_pkg::ETYPE_IPV4, v4flt_pkg::PROTO_TCP, 32'hC0A8_0001, 32'h0A00_0002,
               16'd1234, 16'd81);
    push_frame(42, v4flt_pkg::ETYPE_IPV4, v4flt_pkg::PROTO_UDP, 32'hC0A8_0001, 32'h0A00_0002,
               16'd1234, 16'd80);
    push_frame(50, v4flt_pkg::ETYPE_IPV4, v4flt_pkg::PROTO_TCP, 32'hC0A8_0001, 32'h0A00_0002,
               16'd1234, 16'd80);
    wait_drained();

    // all-ones match values; a write to an unmapped index must change nothing
    write_reg(v4flt_pkg::CFG_SRC_ADDR, 32'hFFFF_FFFF);
    write_reg(v4flt_pkg::CFG_DST_ADDR, 32'hFFFF_FFFF);
    write_reg(v4flt_pkg::CFG_SRC_PORT, 32'h0000_FFFF);
    write_reg(v4flt_pkg::CFG_DST_PORT, 32'h0000_FFFF);
    write_reg(CfgIdxUnused, 32'd0);
    push_frame(54, v4flt_pkg::ETYPE_IPV4, v4flt_pkg::PROTO_TCP, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               16'hFFFF, 16'hFFFF);
    push_frame(42, v4flt_pkg::ETYPE_IPV4, v4flt_pkg::PROTO_UDP, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               16'hFFFF, 16'hFFFE);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      write_reg(v4flt_pkg::CFG_IPV4_ENABLE, 32'($urandom_range(0, 4) != 0));
      write_reg(v4flt_pkg::CFG_SRC_ADDR, pick_match(32'hFFFF_FFFF));
      write_reg(v4flt_pkg::CFG_DST_ADDR, pick_match(32'hFFFF_FFFF));
      write_reg(v4flt_pkg::CFG_SRC_PORT, pick_match(32'h0000_FFFF));
      write_reg(v4flt_pkg::CFG_DST_PORT, pick_match(32'h0000_FFFF));
      // short frames behind a long receiver hold back up the result path
      if (p == 2) rx_long_hold_req = 1'b1;
      target = queued_words + PhaseWords;
      while (queued_words < target) push_random_frame(p == 2);
      wait_drained();
    end

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
